@@ rtl/core/kpe_pkg.sv @@
// Shared types, codes and microprogram for the keypad PIN entry core.
package kpe_pkg;

   localparam int MILLIS_PER_SECOND = 1000;
   localparam logic [15:0] CLEAR_HOLD_RESET = 16'(2 * MILLIS_PER_SECOND);
   localparam int PASSKEY_W = 27;
   localparam int STEP_W = 3;

   typedef enum logic [1:0] {
      OP_KEY   = 2'd0,
      OP_START = 2'd1,
      OP_END   = 2'd2,
      OP_READY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DIGIT      = 2'd0,
      KIND_CONFIRM    = 2'd1,
      KIND_DELETE     = 2'd2,
      KIND_UNASSIGNED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_DISABLED = 2'd0,
      MODE_IDLE     = 2'd1,
      MODE_ACTIVE   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  key_kind;
      logic [3:0]  digit_value;
      logic        delete_index;
      logic        pressed;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                 handled;
      logic                 passkey_valid;
      logic [PASSKEY_W-1:0] passkey;
      logic [3:0]           digit_count;
      logic                 key_dropped;
      logic [1:0]           mode_now;
   } rsp_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_APPLY,
      ACT_ACCUM,
      ACT_CONFIRM
   } act_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_START,
      COND_CONFIRM,
      COND_MORE
   } cond_type;

   typedef struct packed {
      act_type           act;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic start;
      logic confirm;
      logic more;
   } useq_flags_type;

   localparam logic [STEP_W-1:0] STEP_FETCH   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DECIDE  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_APPLY   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_WALK    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_FINISH  = 3'd4;

   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] addr);
      uword_type w;
      unique case (addr)
         STEP_FETCH:  w = '{act: ACT_LOAD,    cond: COND_NO_START, target: STEP_FETCH};
         STEP_DECIDE: w = '{act: ACT_NONE,    cond: COND_CONFIRM,  target: STEP_WALK};
         STEP_APPLY:  w = '{act: ACT_APPLY,   cond: COND_ALWAYS,   target: STEP_FETCH};
         STEP_WALK:   w = '{act: ACT_ACCUM,   cond: COND_MORE,     target: STEP_WALK};
         STEP_FINISH: w = '{act: ACT_CONFIRM, cond: COND_ALWAYS,   target: STEP_FETCH};
         default:     w = '{act: ACT_NONE,    cond: COND_ALWAYS,   target: STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/kpe_useq.sv @@
// Microprogram sequencer: step counter, control store and jump logic.
module kpe_useq (
   input  logic                       clock,
   input  logic                       reset,
   input  kpe_pkg::useq_flags_type    flags,
   output kpe_pkg::uword_type         uword,
   output logic                       busy
);
   import kpe_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take;

   assign uword = ucode_rom(step_ff);
   assign busy  = (step_ff != STEP_FETCH);

   always_comb begin
      unique case (uword.cond)
         COND_NEXT:     take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_START: take = ~flags.start;
         COND_CONFIRM:  take = flags.confirm;
         COND_MORE:     take = flags.more;
         default:       take = 1'b1;
      endcase
      step_in = take ? uword.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/core/kpe_datapath.sv @@
// Datapath: mode, digit buffer, delete timers, passkey accumulator and result register.
module kpe_datapath #(
   parameter int MAX_DIGITS    = 8,
   parameter int DIGIT_BASE    = 10,
   parameter int DEL_KEY_COUNT = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kpe_pkg::uword_type         uword,
   input  logic                       start,
   input  kpe_pkg::req_type           req,
   input  logic                       csr_we,
   input  logic [15:0]                csr_data,
   output kpe_pkg::useq_flags_type    flags,
   output logic                       rsp_strobe,
   output kpe_pkg::rsp_type           rsp
);
   import kpe_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DK_W  = (DEL_KEY_COUNT > 1) ? $clog2(DEL_KEY_COUNT) : 1;

   mode_type             mode_ff, mode_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     walk_ff, walk_in;
   logic [PASSKEY_W-1:0] acc_ff, acc_in;
   logic [31:0]          press_time_ff [DEL_KEY_COUNT];
   logic [31:0]          press_time_in [DEL_KEY_COUNT];
   logic [3:0]           digits_ff [MAX_DIGITS];
   logic                 dig_we;
   logic [15:0]          clear_hold_ff;
   req_type              req_ff, req_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 del_ok;
   logic [DK_W-1:0]      del_idx;
   logic [31:0]          hold;
   logic [3:0]           walk_digit;

   assign del_ok     = ({2'b00, req_ff.delete_index} < 3'(DEL_KEY_COUNT));
   assign del_idx    = DK_W'(req_ff.delete_index);
   assign hold       = req_ff.now_ms - press_time_ff[del_idx];
   assign walk_digit = digits_ff[walk_ff[IDX_W-1:0]];

   assign flags.start   = start;
   assign flags.confirm = (mode_ff == MODE_ACTIVE) && (req_ff.op == OP_KEY)
                          && (req_ff.key_kind == KIND_CONFIRM) && req_ff.pressed;
   assign flags.more    = (walk_ff < count_ff);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      mode_in       = mode_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      acc_in        = acc_ff;
      press_time_in = press_time_ff;
      dig_we        = 1'b0;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      unique case (uword.act)
         ACT_LOAD: begin
            if (start) begin
               req_in  = req;
               acc_in  = '0;
               walk_in = '0;
            end
         end
         ACT_APPLY: begin
            rsp_in.handled       = 1'b0;
            rsp_in.key_dropped   = 1'b0;
            unique case (op_type'(req_ff.op))
               OP_START: begin
                  mode_in  = MODE_ACTIVE;
                  count_in = '0;
               end
               OP_END, OP_READY: begin
                  mode_in = MODE_IDLE;
               end
               OP_KEY: begin
                  if (mode_ff == MODE_ACTIVE) begin
                     rsp_in.handled = 1'b1;
                     unique case (kind_type'(req_ff.key_kind))
                        KIND_DIGIT: begin
                           if (req_ff.pressed
                               && ({1'b0, req_ff.digit_value} < 5'(DIGIT_BASE))) begin
                              if (count_ff < CNT_W'(MAX_DIGITS)) begin
                                 dig_we   = 1'b1;
                                 count_in = count_ff + CNT_W'(1);
                              end else begin
                                 rsp_in.key_dropped = 1'b1;
                              end
                           end
                        end
                        KIND_DELETE: begin
                           if (del_ok) begin
                              if (req_ff.pressed) begin
                                 if (count_ff != '0) begin
                                    count_in = count_ff - CNT_W'(1);
                                 end
                                 press_time_in[del_idx] = req_ff.now_ms;
                              end else begin
                                 if (hold > {16'b0, clear_hold_ff}) begin
                                    count_in = '0;
                                 end
                                 press_time_in[del_idx] = '0;
                              end
                           end
                        end
                        KIND_CONFIRM, KIND_UNASSIGNED: begin
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
            rsp_strobe_in        = 1'b1;
            rsp_in.passkey_valid = 1'b0;
            rsp_in.passkey       = '0;
            rsp_in.digit_count   = 4'(count_in);
            rsp_in.mode_now      = mode_in;
         end
         ACT_ACCUM: begin
            if (flags.more) begin
               acc_in  = PASSKEY_W'(acc_ff * PASSKEY_W'(DIGIT_BASE))
                         + PASSKEY_W'(walk_digit);
               walk_in = walk_ff + CNT_W'(1);
            end
         end
         ACT_CONFIRM: begin
            mode_in              = MODE_IDLE;
            rsp_strobe_in        = 1'b1;
            rsp_in.handled       = 1'b1;
            rsp_in.passkey_valid = 1'b1;
            rsp_in.passkey       = acc_ff;
            rsp_in.digit_count   = 4'(count_ff);
            rsp_in.key_dropped   = 1'b0;
            rsp_in.mode_now      = MODE_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_DISABLED;
         count_ff      <= '0;
         clear_hold_ff <= CLEAR_HOLD_RESET;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < DEL_KEY_COUNT; i++) begin
            press_time_ff[i] <= '0;
         end
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         press_time_ff <= press_time_in;
         if (csr_we) begin
            clear_hold_ff <= csr_data;
         end
      end
      walk_ff <= walk_in;
      acc_ff  <= acc_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      if (dig_we) begin
         digits_ff[count_ff[IDX_W-1:0]] <= req_ff.digit_value;
      end
   end

endmodule

@@ rtl/core/keypad_pin_entry_core.sv @@
// Top level of the keypad PIN entry core: microcode sequencer plus datapath.
// A transaction is taken when start is high and busy is low. Every transaction
// gives exactly one result, shown on rsp for one cycle with rsp_strobe high;
// the receiver cannot stall it. A transaction other than a confirm press in
// active mode passes through the decide and apply steps before the next
// acceptance. A confirm press walks the stored digits through the multiply-add
// step of the datapath, one digit per cycle, then passes through the finish
// step before the next acceptance. The clear-hold register is written over
// the csr channel while busy is low and no transaction is being started.
module keypad_pin_entry_core #(
   parameter int MAX_DIGITS    = 8,
   parameter int DIGIT_BASE    = 10,
   parameter int DEL_KEY_COUNT = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  kpe_pkg::req_type  req,
   output logic              rsp_strobe,
   output kpe_pkg::rsp_type  rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import kpe_pkg::*;

   uword_type      uword;
   useq_flags_type flags;

   assign csr_ready = ~busy & ~start;

   kpe_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uword (uword),
      .busy  (busy)
   );

   kpe_datapath #(
      .MAX_DIGITS    (MAX_DIGITS),
      .DIGIT_BASE    (DIGIT_BASE),
      .DEL_KEY_COUNT (DEL_KEY_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .uword      (uword),
      .start      (start & ~busy),
      .req        (req),
      .csr_we     (csr_valid & csr_ready),
      .csr_data   (csr_data),
      .flags      (flags),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

endmodule

@@ tb/tb_keypad_pin_entry_core.sv @@
// Self-checking testbench for the keypad PIN entry core with a built-in mode and digit predictor.
`timescale 1ns / 1ps

module tb_keypad_pin_entry_core;
   import kpe_pkg::*;

   localparam int MAX_DIGITS = 8;
   localparam int DIGIT_BASE = 10;
   localparam int DEL_KEY_COUNT = 2;
   localparam int RANDOM_ITEMS = 1300;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req;
   logic rsp_strobe;
   rsp_type rsp;
   logic csr_valid;
   logic csr_ready;
   logic [15:0] csr_data;

   logic [15:0] hold_limit = CLEAR_HOLD_RESET;
   mode_type entry_mode = MODE_DISABLED;
   logic [3:0] digit_buf [MAX_DIGITS];
   logic [3:0] digit_total = '0;
   logic [31:0] delete_stamp [DEL_KEY_COUNT] = '{default: '0};

   rsp_type pending_results[$];
   rsp_type expected_rsp;
   int failures = 0;
   int item_count = 0;
   bit steady_flow = 1'b0;
   logic [31:0] uptime;

   keypad_pin_entry_core #(
      .MAX_DIGITS(MAX_DIGITS),
      .DIGIT_BASE(DIGIT_BASE),
      .DEL_KEY_COUNT(DEL_KEY_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_strobe(rsp_strobe),
      .rsp(rsp),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type advance_pin_entry(input req_type r);
      rsp_type o;
      logic [63:0] acc;
      logic [31:0] hold;
      o = '0;
      case (op_type'(r.op))
         OP_START: begin
            entry_mode = MODE_ACTIVE;
            digit_total = '0;
         end
         OP_END, OP_READY: entry_mode = MODE_IDLE;
         default: if (entry_mode == MODE_ACTIVE) begin
            o.handled = 1'b1;
            case (kind_type'(r.key_kind))
               KIND_DIGIT: if (r.pressed && r.digit_value < DIGIT_BASE) begin
                  if (digit_total < MAX_DIGITS) begin
                     digit_buf[digit_total] = r.digit_value;
                     digit_total++;
                  end else begin
                     o.key_dropped = 1'b1;
                  end
               end
               KIND_CONFIRM: if (r.pressed) begin
                  acc = '0;
                  for (int i = 0; i < digit_total; i++) acc = acc * DIGIT_BASE + digit_buf[i];
                  o.passkey = acc[PASSKEY_W-1:0];
                  o.passkey_valid = 1'b1;
                  entry_mode = MODE_IDLE;
               end
               KIND_DELETE: if (r.delete_index < DEL_KEY_COUNT) begin
                  if (r.pressed) begin
                     if (digit_total > 0) digit_total--;
                     delete_stamp[r.delete_index] = r.now_ms;
                  end else begin
                     hold = r.now_ms - delete_stamp[r.delete_index];
                     if (hold > {16'd0, hold_limit}) digit_total = '0;
                     delete_stamp[r.delete_index] = '0;
                  end
               end
               default: ;
            endcase
         end
      endcase
      o.digit_count = digit_total;
      o.mode_now = entry_mode;
      return o;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [1:0] kind,
                                        input logic [3:0] digit, input logic del,
                                        input logic pressed, input logic [31:0] now);
      req_type r;
      r.op = op;
      r.key_kind = kind;
      r.digit_value = digit;
      r.delete_index = del;
      r.pressed = pressed;
      r.now_ms = now;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("Result strobe with no transaction outstanding.");
            failures++;
         end else begin
            expected_rsp = pending_results.pop_front();
            check_field("handled", 32'(expected_rsp.handled), 32'(rsp.handled));
            check_field("passkey_valid", 32'(expected_rsp.passkey_valid),
                        32'(rsp.passkey_valid));
            check_field("passkey", 32'(expected_rsp.passkey), 32'(rsp.passkey));
            check_field("digit_count", 32'(expected_rsp.digit_count), 32'(rsp.digit_count));
            check_field("key_dropped", 32'(expected_rsp.key_dropped), 32'(rsp.key_dropped));
            check_field("mode_now", 32'(expected_rsp.mode_now), 32'(rsp.mode_now));
         end
      end
   end

   task automatic apply_item(input req_type r);
      int gap;
      @(negedge clock);
      req <= r;
      start <= 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_results.push_back(advance_pin_entry(r));
      item_count++;
      if (!steady_flow && $urandom_range(0, 99) < 25) begin
         gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 14 : 3);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (MAX_DIGITS + 8) @(negedge clock);
   endtask

   task automatic write_clear_hold(input logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      hold_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_disabled_mode();
      apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd5, 1'b0, 1'b1, 32'd0));
      apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF));
      apply_item(make_req(OP_READY, KIND_DIGIT, 4'd0, 1'b0, 1'b0, 32'd0));
      apply_item(make_req(OP_KEY, KIND_CONFIRM, 4'd0, 1'b0, 1'b1, 32'd10));
      apply_item(make_req(OP_END, KIND_UNASSIGNED, 4'd15, 1'b1, 1'b1, 32'd20));
   endtask

   task automatic test_digit_entry();
      apply_item(make_req(OP_START, KIND_DIGIT, 4'd0, 1'b0, 1'b0, 32'd30));
      apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd10, 1'b0, 1'b1, 32'd31));
      apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd15, 1'b0, 1'b1, 32'd32));
      apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd9, 1'b0, 1'b0, 32'd33));
      apply_item(make_req(OP_KEY, KIND_UNASSIGNED, 4'd3, 1'b0, 1'b1, 32'd34));
      apply_item(make_req(OP_KEY, KIND_CONFIRM, 4'd0, 1'b0, 1'b0, 32'd35));
      apply_item(make_req(OP_KEY, KIND_CONFIRM, 4'd0, 1'b0, 1'b1, 32'd36));
      apply_item(make_req(OP_START, KIND_DIGIT, 4'd0, 1'b0, 1'b0, 32'd40));
      repeat (MAX_DIGITS) apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd9, 1'b0, 1'b1, 32'd41));
      apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd0, 1'b0, 1'b1, 32'd42));
      apply_item(make_req(OP_KEY, KIND_CONFIRM, 4'd0, 1'b0, 1'b1, 32'd43));
      apply_item(make_req(OP_START, KIND_DIGIT, 4'd0, 1'b0, 1'b0, 32'd44));
      apply_item(make_req(OP_START, KIND_DIGIT, 4'd0, 1'b0, 1'b0, 32'd45));
   endtask

   task automatic test_clear_hold();
      logic [15:0] settings [4];
      logic [31:0] t;
      settings = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), CLEAR_HOLD_RESET};
      foreach (settings[s]) begin
         write_clear_hold(settings[s]);
         t = 32'hFFFF_FFFF - $urandom_range(0, 70000);
         apply_item(make_req(OP_START, KIND_DIGIT, 4'd0, 1'b0, 1'b0, t));
         apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b1, 1'b1, t));
         apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd7, 1'b0, 1'b1, t));
         apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd3, 1'b0, 1'b1, t));
         apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b1, 1'b0, t + hold_limit));
         apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b0, 1'b1, t));
         apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b0, 1'b0, t + hold_limit + 1));
         apply_item(make_req(OP_KEY, KIND_DIGIT, 4'd5, 1'b0, 1'b1, t));
         apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b1, 1'b0, {16'd0, hold_limit}));
         apply_item(make_req(OP_KEY, KIND_DELETE, 4'd0, 1'b1, 1'b0, hold_limit + 32'd1));
         apply_item(make_req(OP_END, KIND_DELETE, 4'd0, 1'b0, 1'b0, t));
      end
   endtask

   task automatic run_sessions(input int item_goal);
      int first;
      logic [31:0] hold;
      logic del;
      first = item_count;
      while (item_count - first < item_goal) begin
         if ($urandom_range(0, 99) < 25) begin
            apply_item(make_req($urandom_range(0, 1) ? OP_KEY : 2'($urandom_range(0, 3)),
                                2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom));
         end else begin
            apply_item(make_req(OP_START, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                uptime));
            repeat ($urandom_range(0, 11)) begin
               uptime += $urandom_range(1, 400);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: apply_item(make_req(OP_KEY, KIND_DIGIT,
                     4'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
                                                    : $urandom_range(0, 9)),
                     1'($urandom_range(0, 1)), 1'b1, uptime));
                  5: apply_item(make_req(OP_KEY, 2'($urandom_range(0, 1)),
                                         4'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1)), 1'b0, uptime));
                  6: apply_item(make_req(OP_KEY, KIND_UNASSIGNED, 4'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), uptime));
                  default: begin
                     del = 1'($urandom_range(0, 1));
                     apply_item(make_req(OP_KEY, KIND_DELETE, 4'($urandom_range(0, 15)), del,
                                         1'b1, uptime));
                     case ($urandom_range(0, 2))
                        0: hold = hold_limit + $urandom_range(0, 3) - 1;
                        1: hold = $urandom_range(0, hold_limit);
                        default: hold = $urandom_range(0, 2 * hold_limit + 100);
                     endcase
                     uptime += hold;
                     apply_item(make_req(OP_KEY, KIND_DELETE, 4'($urandom_range(0, 15)), del,
                                         1'b0, uptime));
                  end
               endcase
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: apply_item(make_req(OP_KEY, KIND_CONFIRM,
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b1, uptime));
               7: apply_item(make_req(OP_END, 2'($urandom_range(0, 3)),
                                      4'($urandom_range(0, 15)),
                                      1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), uptime));
               8: apply_item(make_req(OP_READY, 2'($urandom_range(0, 3)),
                                      4'($urandom_range(0, 15)),
                                      1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), uptime));
               default: ;
            endcase
         end
      end
   endtask

   task automatic test_random_traffic();
      write_clear_hold(16'($urandom_range(0, 3000)));
      uptime = $urandom;
      run_sessions(RANDOM_ITEMS / 3);
      write_clear_hold(16'hFFFF);
      uptime = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      steady_flow = 1'b1;
      run_sessions(RANDOM_ITEMS / 3);
      steady_flow = 1'b0;
      write_clear_hold(16'd0);
      run_sessions(RANDOM_ITEMS / 3);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_disabled_mode();
      test_digit_entry();
      test_clear_hold();
      test_random_traffic();
      wait_idle();
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived.", pending_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
